### design/assert_macros.svh
// Assertion helpers shared by the design files.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property checked on every rising edge outside reset.
`define FSS_ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Plain invariant checked on every rising edge outside reset.
`define FSS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

### design/fss_pkg.sv
`default_nettype none

package fss_pkg;

  localparam int NumChars = 16;
  localparam int CharW    = 8;
  localparam int IdxW     = 5;
  localparam int BaseW    = 8;
  localparam int ScoreW   = 21;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPatternLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCharsLow      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCharsHigh     = 2'd2;

  localparam logic [CharW-1:0] CharSlash     = 8'h2F;
  localparam logic [CharW-1:0] CharBackslash = 8'h5C;
  localparam logic [CharW-1:0] CharDot       = 8'h2E;
  localparam logic [CharW-1:0] CharUnder     = 8'h5F;
  localparam logic [CharW-1:0] CharDash      = 8'h2D;
  localparam logic [CharW-1:0] CharUpperA    = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ    = 8'h5A;
  localparam logic [CharW-1:0] FoldOffset    = 8'h20;

  localparam logic [ScoreW-1:0] BasenameBonus = 21'h100000;
  localparam logic [ScoreW-1:0] EmptyScore    = 21'd1;

  typedef logic [NumChars-1:0][CharW-1:0] pat_chars_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              matched;
  } fss_result_t;

  function automatic logic is_upper(input logic [CharW-1:0] c);
    return (c >= CharUpperA) && (c <= CharUpperZ);
  endfunction

  function automatic logic [CharW-1:0] fold_lower(input logic [CharW-1:0] c);
    return is_upper(c) ? c + FoldOffset : c;
  endfunction

  function automatic logic is_slash(input logic [CharW-1:0] c);
    return (c == CharSlash) || (c == CharBackslash);
  endfunction

  function automatic logic is_sep(input logic [CharW-1:0] c);
    return is_slash(c) || (c == CharDot) || (c == CharUnder) || (c == CharDash);
  endfunction

endpackage

`default_nettype wire

### design/fss_core.sv
`default_nettype none

`include "assert_macros.svh"

module fss_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        step_i,
  input  wire [fss_pkg::CharW-1:0]   char_i,
  input  wire                        last_i,
  input  wire [fss_pkg::IdxW-1:0]    pat_len_i,
  input  fss_pkg::pat_chars_t        pat_chars_i,
  output fss_pkg::fss_result_t       result_o
);

  logic [fss_pkg::IdxW-1:0]  idx_r, idx_nxt, idx_upd;
  logic [fss_pkg::BaseW-1:0] base_r, base_nxt, base_upd;
  logic [fss_pkg::IdxW-1:0]  bcount_r, bcount_nxt, bcount_upd;
  logic                      prev_hit_r, prev_hit_nxt;
  logic [fss_pkg::CharW-1:0] prev_char_r, prev_char_nxt;
  logic                      at_start_r, at_start_nxt;

  logic                      sensitive;
  logic                      hit;
  logic [fss_pkg::CharW-1:0] pchar;
  logic [3:0]                gain;

  always_comb begin
    // Any uppercase letter among the active pattern characters makes the
    // comparison exact.
    sensitive = 1'b0;
    for (int i = 0; i < fss_pkg::NumChars; i++) begin
      if ((fss_pkg::IdxW'(i) < pat_len_i) && fss_pkg::is_upper(pat_chars_i[i])) begin
        sensitive = 1'b1;
      end
    end

    pchar = pat_chars_i[idx_r[3:0]];
    hit   = (idx_r < pat_len_i) &&
            (sensitive ? (char_i == pchar)
                       : (fss_pkg::fold_lower(char_i) == fss_pkg::fold_lower(pchar)));

    gain = 4'd1;
    if (prev_hit_r) begin
      gain = gain + 4'd2;
    end
    if (at_start_r || fss_pkg::is_sep(prev_char_r)) begin
      gain = gain + 4'd3;
    end
    if (fss_pkg::is_upper(char_i) && fss_pkg::is_upper(pchar)) begin
      gain = gain + 4'd2;
    end

    base_upd = hit ? base_r + fss_pkg::BaseW'(gain) : base_r;
    idx_upd  = hit ? idx_r + 5'd1 : idx_r;
    // A slash moves the basename start, even after the pattern is complete.
    if (fss_pkg::is_slash(char_i)) begin
      bcount_upd = '0;
    end else if (hit) begin
      bcount_upd = bcount_r + 5'd1;
    end else begin
      bcount_upd = bcount_r;
    end

    if (pat_len_i == '0) begin
      result_o.score   = fss_pkg::EmptyScore;
      result_o.matched = 1'b1;
    end else if (idx_upd >= pat_len_i) begin
      result_o.score   = fss_pkg::ScoreW'(base_upd) + {13'd0, bcount_upd, 3'd0} +
                         ((bcount_upd >= pat_len_i) ? fss_pkg::BasenameBonus : '0);
      result_o.matched = 1'b1;
    end else begin
      result_o.score   = '0;
      result_o.matched = 1'b0;
    end

    if (last_i) begin
      idx_nxt       = '0;
      base_nxt      = '0;
      bcount_nxt    = '0;
      prev_hit_nxt  = 1'b0;
      prev_char_nxt = '0;
      at_start_nxt  = 1'b1;
    end else begin
      idx_nxt       = idx_upd;
      base_nxt      = base_upd;
      bcount_nxt    = bcount_upd;
      prev_hit_nxt  = hit;
      prev_char_nxt = char_i;
      at_start_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      base_r      <= '0;
      bcount_r    <= '0;
      prev_hit_r  <= 1'b0;
      prev_char_r <= '0;
      at_start_r  <= 1'b1;
    end else if (step_i) begin
      idx_r       <= idx_nxt;
      base_r      <= base_nxt;
      bcount_r    <= bcount_nxt;
      prev_hit_r  <= prev_hit_nxt;
      prev_char_r <= prev_char_nxt;
      at_start_r  <= at_start_nxt;
    end
  end

  `FSS_ASSERT_ALWAYS(a_bcount_le_idx, bcount_r <= idx_r,
                     "basename count exceeds matched pattern characters")
  `FSS_ASSERT_IMPL(a_last_clears, step_i && last_i |=> (idx_r == '0) && at_start_r,
                   "candidate state not cleared after last character")

endmodule

`default_nettype wire

### design/fuzzy_subsequence_scorer.sv
// Streaming fuzzy subsequence scorer.
// Candidate path bytes enter on the in_ channel (in_char_in, in_last_char),
// one transfer per byte. The pattern and its length are written on the cfg_
// port (cfg_we, cfg_index, cfg_data); the user must write them only while no
// candidate is in flight, as the block does not enforce it. One result
// transfer (out_match_score, out_matched) leaves on the out_ channel for
// every byte flagged last; other bytes produce nothing. Throughput is one
// byte per cycle while in_ready stays high. A byte is captured in an input
// register, scored against the pattern character at the current match
// position, and a last byte, once it leaves the input register, writes the
// result register, which drives out_valid. The per-byte critical path is the
// pattern character select, compare and the small score add.
// Reset clears the pattern registers and the candidate state; both valid
// flags drop. If the receiver stalls with a result waiting, ordinary bytes
// keep flowing into the scorer; a second last byte waits in the input
// register, and in_ready falls only when that register cannot drain.
`default_nettype none

`include "assert_macros.svh"

module fuzzy_subsequence_scorer #(
  parameter int MAX_PATTERN = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [fss_pkg::CharW-1:0]     in_char_in,
  input  wire                          in_last_char,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [fss_pkg::ScoreW-1:0]   out_match_score,
  output logic                         out_matched,
  input  wire                          cfg_we,
  input  wire [fss_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire [fss_pkg::CfgDataW-1:0]  cfg_data
);

  localparam logic [fss_pkg::IdxW-1:0] MaxLen = fss_pkg::IdxW'(MAX_PATTERN);

  // Configuration registers.
  logic [fss_pkg::IdxW-1:0]    pat_len_r;
  logic [fss_pkg::CfgDataW-1:0] chars_low_r;
  logic [fss_pkg::CfgDataW-1:0] chars_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r    <= '0;
      chars_low_r  <= '0;
      chars_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fss_pkg::RegPatternLength: pat_len_r    <= cfg_data[fss_pkg::IdxW-1:0];
        fss_pkg::RegCharsLow:      chars_low_r  <= cfg_data;
        fss_pkg::RegCharsHigh:     chars_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lengths beyond the supported maximum act as the maximum.
  logic [fss_pkg::IdxW-1:0] eff_len;
  fss_pkg::pat_chars_t      pat_chars;

  assign eff_len   = (pat_len_r > MaxLen) ? MaxLen : pat_len_r;
  assign pat_chars = {chars_high_r, chars_low_r};

  // Input register.
  logic                      s1_valid_r, s1_valid_nxt;
  logic [fss_pkg::CharW-1:0] s1_char_r;
  logic                      s1_last_r;
  logic                      s1_adv;
  logic                      in_xfer;

  // A byte that is not last always drains; a last byte needs room in the
  // result register.
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_last_char;
    end
  end

  // Matching and scoring for the byte in the input register.
  fss_pkg::fss_result_t result;

  fss_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (s1_adv),
    .char_i      (s1_char_r),
    .last_i      (s1_last_r),
    .pat_len_i   (eff_len),
    .pat_chars_i (pat_chars),
    .result_o    (result)
  );

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic out_load;

  assign out_load = s1_adv && s1_last_r;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_match_score <= result.score;
      out_matched     <= result.matched;
    end
  end

  assign out_valid = out_valid_r;

  // A last byte must not overrun a result that is still waiting.
  `FSS_ASSERT_IMPL(a_last_held, s1_valid_r && s1_last_r && out_valid_r && !out_ready |=>
                   s1_valid_r && s1_last_r,
                   "last byte left the input register while result stalled")
  // An unmatched result always carries a zero score.
  `FSS_ASSERT_IMPL(a_unmatched_zero, out_valid_r && !out_matched |-> out_match_score == '0,
                   "unmatched result with nonzero score")

endmodule

`default_nettype wire
